// File: hdl/srs_pkg.sv
// shared types and constants for the selective repeat sender
`timescale 1ns / 1ps
package srs_pkg;
  localparam int WindowSizeDef = 6;
  localparam int SeqSpaceDef   = 12;
  localparam int MaxResults    = 6;
  localparam int SumW          = 14;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_TIMER = 2'd2;

  localparam logic [1:0] TCMD_NONE  = 2'd0;
  localparam logic [1:0] TCMD_START = 2'd1;
  localparam logic [1:0] TCMD_STOP  = 2'd2;

  localparam logic [1:0] ST_SENT    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_ACKED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_DECIDE, S_SLIDE, S_SCAN, S_READ, S_OUT
  } state_t;
endpackage

// File: hdl/srs_if.sv
// request channel interfaces of the selective repeat sender
`timescale 1ns / 1ps
interface srs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] pkt_seq_in;
  logic [15:0] pkt_ack_in;
  logic [15:0] pkt_sum_in;
  logic [63:0] data_word_low;
  logic [63:0] data_word_mid;
  logic [31:0] data_word_high;
  modport source (output valid, kind, pkt_seq_in, pkt_ack_in, pkt_sum_in,
                  data_word_low, data_word_mid, data_word_high, input ready);
  modport sink (input valid, kind, pkt_seq_in, pkt_ack_in, pkt_sum_in,
                data_word_low, data_word_mid, data_word_high, output ready);
endinterface

interface srs_out_if;
  logic              valid;
  logic              ready;
  logic              has_packet;
  logic [3:0]        out_seq;
  logic signed [13:0] out_sum;
  logic [63:0]       out_word_low;
  logic [63:0]       out_word_mid;
  logic [31:0]       out_word_high;
  logic [1:0]        timer_cmd;
  logic [1:0]        status;
  logic              last;
  modport source (output valid, has_packet, out_seq, out_sum, out_word_low,
                  out_word_mid, out_word_high, timer_cmd, status, last,
                  input ready);
  modport sink (input valid, has_packet, out_seq, out_sum, out_word_low,
                out_word_mid, out_word_high, timer_cmd, status, last,
                output ready);
endinterface

// File: hdl/selective_repeat_sender.sv
// selective repeat arq sender top level
// Usage: requests enter on in_ch (kind plus ack fields and 20 payload bytes);
// results leave on out_ch, one or more per request, the final one with last.
// A send gives one packet result, an ack gives one status result, a timer
// expiry gives one result per resent packet (up to six) or one empty result.
// Every request is worked by a sequencer around one shared adder: the 20
// payload bytes are summed one per cycle, then the window logic decides,
// waiting on a stalled receiver before it writes the result of a send or
// an ack. A taken ack then slides the base one slot per cycle, up to
// SEQ_SPACE slots. A timer expiry scans one slot per cycle, pausing at each
// resent packet for a store read state and an output state that waits on
// the receiver; a closing state ends the request.
// in_ch.ready is high only while the sequencer is idle; a stalled receiver
// holds the result register and the sequencer waits on it.
// Reset (synchronous, rst) clears base, next sequence and all flags; the
// packet store is not cleared, only slots with a running timer are read.
`timescale 1ns / 1ps
module selective_repeat_sender
  import srs_pkg::*;
#(
  parameter int WINDOW_SIZE = WindowSizeDef,
  parameter int SEQ_SPACE   = SeqSpaceDef
) (
  input logic clk,
  input logic rst,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch
);
  localparam int SW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int CW = $clog2(SEQ_SPACE + 1);

  state_t state, state_next;

  // captured request
  logic [1:0]  kind;
  logic [15:0] ack_f, sum_f;
  logic [159:0] data;
  logic [4:0]  byte_cnt;
  logic signed [17:0] acc;

  logic [SW-1:0] window_base, next_sequence;
  logic [SEQ_SPACE-1:0] acked_flags, timing_flags;
  logic [CW-1:0] scan;
  logic [2:0] n_out;

  // packet store
  logic [63:0] stored_low [SEQ_SPACE];
  logic [63:0] stored_mid [SEQ_SPACE];
  logic [31:0] stored_high [SEQ_SPACE];
  logic [SumW-1:0] stored_sum [SEQ_SPACE];
  logic [63:0] rd_low, rd_mid;
  logic [31:0] rd_high;
  logic [SumW-1:0] rd_sum;
  logic [SW-1:0] rd_idx;

  // window test: distance from base below window size
  function automatic logic in_win(input logic [SW-1:0] s, input logic [SW-1:0] b);
    logic [SW:0] d;
    begin
      d = (s >= b) ? ({1'b0, s} - {1'b0, b})
                   : ({1'b0, s} + (SW+1)'(SEQ_SPACE) - {1'b0, b});
      in_win = (32'(d) < WINDOW_SIZE) && (32'(s) < SEQ_SPACE);
    end
  endfunction

  logic [SW-1:0] scan_i;
  assign scan_i = scan[SW-1:0];
  logic [SW-1:0] ack_i;
  assign ack_i = ack_f[SW-1:0];
  logic ack_ok;
  assign ack_ok = (acc == 18'(signed'(sum_f))) && !ack_f[15] &&
                  ({16'd0, ack_f} < 32'(SEQ_SPACE)) && in_win(ack_i, window_base);
  logic scan_hit;
  assign scan_hit = timing_flags[scan_i] && !acked_flags[scan_i] &&
                    in_win(scan_i, window_base);

  // resend candidates beyond the current scan slot, for the last flag
  logic [SEQ_SPACE-1:0] resend_hits, later_slots;
  logic more_hits;
  always_comb begin
    for (int i = 0; i < SEQ_SPACE; i++) begin
      resend_hits[i] = timing_flags[i] && !acked_flags[i] && in_win(SW'(i), window_base);
      later_slots[i] = (i > 32'(scan));
    end
  end
  assign more_hits = |(resend_hits & later_slots);

  logic out_free;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_ch.valid) state_next = S_SUM;
      S_SUM:    if (byte_cnt == 5'd19) state_next = S_DECIDE;
      S_DECIDE: begin
        if (kind == KIND_TIMER) state_next = S_SCAN;
        else if (out_free) state_next = (kind == KIND_ACK && ack_ok) ? S_SLIDE : S_IDLE;
      end
      S_SLIDE:  if (!acked_flags[window_base] || scan == CW'(SEQ_SPACE)) state_next = S_IDLE;
      S_SCAN: begin
        if (scan == CW'(SEQ_SPACE) || n_out == 3'(MaxResults)) begin
          if (out_free) state_next = S_IDLE;
        end else if (scan_hit) state_next = S_READ;
      end
      S_READ:   state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_SCAN;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // store read port
  always_ff @(posedge clk) begin
    rd_low  <= stored_low[rd_idx];
    rd_mid  <= stored_mid[rd_idx];
    rd_high <= stored_high[rd_idx];
    rd_sum  <= stored_sum[rd_idx];
  end
  assign rd_idx = scan_i;

  // store write port
  logic wr_en;
  assign wr_en = (state == S_DECIDE) && kind == KIND_SEND && out_free &&
                 in_win(next_sequence, window_base);
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stored_low[next_sequence]  <= data[63:0];
      stored_mid[next_sequence]  <= data[127:64];
      stored_high[next_sequence] <= data[159:128];
      stored_sum[next_sequence]  <= SumW'(acc);
    end
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
      next_sequence <= '0;
      acked_flags <= '0;
      timing_flags <= '0;
      out_ch.valid <= 1'b0;
      scan <= '0;
      n_out <= '0;
      byte_cnt <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          kind  <= in_ch.kind;
          ack_f <= in_ch.pkt_ack_in;
          sum_f <= in_ch.pkt_sum_in;
          data  <= {in_ch.data_word_high, in_ch.data_word_mid, in_ch.data_word_low};
          byte_cnt <= '0;
          scan <= '0;
          n_out <= '0;
          // seed accumulator: seq + ack for acks, seq - 1 for sends
          if (in_ch.kind == KIND_SEND) acc <= 18'(next_sequence) - 18'sd1;
          else acc <= 18'(signed'(in_ch.pkt_seq_in)) + 18'(signed'(in_ch.pkt_ack_in));
        end
        S_SUM: begin
          // one payload byte per cycle through the shared adder
          acc <= acc + 18'(data[7:0]);
          data <= {data[7:0], data[159:8]};
          byte_cnt <= byte_cnt + 5'd1;
        end
        S_DECIDE: if (kind != KIND_TIMER && out_free) begin
          out_ch.valid <= 1'b1;
          out_ch.has_packet <= 1'b0;
          out_ch.out_seq <= '0;
          out_ch.out_sum <= '0;
          out_ch.out_word_low <= '0;
          out_ch.out_word_mid <= '0;
          out_ch.out_word_high <= '0;
          out_ch.timer_cmd <= TCMD_NONE;
          out_ch.last <= 1'b1;
          case (kind)
            KIND_SEND: begin
              if (in_win(next_sequence, window_base)) begin
                out_ch.has_packet <= 1'b1;
                out_ch.out_seq <= 4'(next_sequence);
                out_ch.out_sum <= SumW'(acc);
                out_ch.out_word_low <= data[63:0];
                out_ch.out_word_mid <= data[127:64];
                out_ch.out_word_high <= data[159:128];
                out_ch.status <= ST_SENT;
                acked_flags[next_sequence] <= 1'b0;
                if (!timing_flags[next_sequence]) begin
                  timing_flags[next_sequence] <= 1'b1;
                  out_ch.timer_cmd <= TCMD_START;
                end
                next_sequence <= (32'(next_sequence) == SEQ_SPACE - 1) ? '0
                                 : next_sequence + SW'(1);
              end else out_ch.status <= ST_REFUSED;
            end
            KIND_ACK: begin
              if (ack_ok) begin
                out_ch.status <= ST_ACKED;
                acked_flags[ack_i] <= 1'b1;
                if (timing_flags[ack_i]) begin
                  timing_flags[ack_i] <= 1'b0;
                  out_ch.timer_cmd <= TCMD_STOP;
                end
              end else out_ch.status <= ST_IGNORED;
            end
            default: out_ch.status <= ST_IGNORED;
          endcase
        end
        S_SLIDE: if (acked_flags[window_base] && scan != CW'(SEQ_SPACE)) begin
          acked_flags[window_base] <= 1'b0;
          window_base <= (32'(window_base) == SEQ_SPACE - 1) ? '0 : window_base + SW'(1);
          scan <= scan + CW'(1);
        end
        S_SCAN: begin
          if (scan == CW'(SEQ_SPACE) || n_out == 3'(MaxResults)) begin
            if (out_free && n_out == '0) begin
              out_ch.valid <= 1'b1;
              out_ch.has_packet <= 1'b0;
              out_ch.out_seq <= '0;
              out_ch.out_sum <= '0;
              out_ch.out_word_low <= '0;
              out_ch.out_word_mid <= '0;
              out_ch.out_word_high <= '0;
              out_ch.timer_cmd <= TCMD_NONE;
              out_ch.status <= ST_SENT;
              out_ch.last <= 1'b1;
            end
          end else if (!scan_hit) scan <= scan + CW'(1);
        end
        S_OUT: if (out_free) begin
          out_ch.valid <= 1'b1;
          out_ch.has_packet <= 1'b1;
          out_ch.out_seq <= 4'(scan_i);
          out_ch.out_sum <= rd_sum;
          out_ch.out_word_low <= rd_low;
          out_ch.out_word_mid <= rd_mid;
          out_ch.out_word_high <= rd_high;
          out_ch.timer_cmd <= TCMD_START;
          out_ch.status <= ST_SENT;
          // final resend when the cap is reached or no candidate remains
          out_ch.last <= (n_out == 3'(MaxResults - 1)) || !more_hits;
          n_out <= n_out + 3'd1;
          scan <= scan + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // result held steady while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid &&
      $stable({out_ch.has_packet, out_ch.out_seq, out_ch.out_sum, out_ch.timer_cmd,
               out_ch.status, out_ch.last}));

  // a slot is never both timed and acknowledged
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    (timing_flags & acked_flags) == '0);

  // sequence pointers stay inside the sequence space
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(window_base) < SEQ_SPACE && 32'(next_sequence) < SEQ_SPACE);

  // a result without a packet always closes its request
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.has_packet |-> out_ch.last);

  // resend count never passes the cap
  a_nout_cap: assert property (@(posedge clk) disable iff (rst)
    n_out <= 3'(MaxResults));
endmodule

// File: tb/tb_top.sv
// self-checking testbench for the selective repeat sender
`timescale 1ns / 1ps
module tb_top;
  import srs_pkg::*;

  localparam int WIN = 6;
  localparam int SEQN = 12;

  typedef struct packed {
    logic        has_packet;
    logic [3:0]  out_seq;
    logic [13:0] out_sum;
    logic [63:0] w_low;
    logic [63:0] w_mid;
    logic [31:0] w_high;
    logic [1:0]  timer_cmd;
    logic [1:0]  status;
    logic        last;
  } pkt_result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] seq_f;
    logic [15:0] ack_f;
    logic [15:0] sum_f;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
    logic        has_exp;
    logic [1:0]  exp_status;
  } stim_row_t;

  logic clk;
  logic rst;
  srs_in_if in_ch ();
  srs_out_if out_ch ();

  selective_repeat_sender dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // sender-side window state mirror
  int unsigned win_base;
  int unsigned next_seq;
  bit acked[SEQN];
  bit timing[SEQN];
  logic [63:0] st_lo[SEQN];
  logic [63:0] st_mid[SEQN];
  logic [31:0] st_hi[SEQN];
  logic [13:0] st_sum[SEQN];

  pkt_result_t pending_results[$];
  // one entry per request: flag for a typed-in status, then the status
  logic [2:0] pinned_status[$];
  int errors;
  int mismatches;
  bit rx_stall_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** selective_repeat_sender: FAILED **");
    $finish;
  end

  function automatic int byte_sum(logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
    int t;
    t = 0;
    for (int i = 0; i < 8; i++) t += lo[8*i +: 8] + mid[8*i +: 8];
    for (int i = 0; i < 4; i++) t += hi[8*i +: 8];
    return t;
  endfunction

  function automatic bit window_has(int unsigned s);
    int unsigned top;
    top = (win_base + WIN - 1) % SEQN;
    if (win_base <= top) return s >= win_base && s <= top;
    return s >= win_base || s <= top;
  endfunction

  function automatic pkt_result_t empty_result(logic [1:0] st);
    pkt_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // advance the mirror by one request and queue its results
  task automatic predict_request(input stim_row_t r);
    pkt_result_t res;
    int unsigned s;
    int sum;
    int a;
    int n;
    n = 0;
    if (r.kind == KIND_SEND) begin
      s = next_seq;
      if (window_has(s)) begin
        sum = int'(s) - 1 + byte_sum(r.lo, r.mid, r.hi);
        st_lo[s] = r.lo; st_mid[s] = r.mid; st_hi[s] = r.hi;
        st_sum[s] = sum[13:0];
        acked[s] = 1'b0;
        res = empty_result(ST_SENT);
        res.has_packet = 1'b1; res.out_seq = s[3:0]; res.out_sum = st_sum[s];
        res.w_low = r.lo; res.w_mid = r.mid; res.w_high = r.hi;
        if (!timing[s]) begin
          timing[s] = 1'b1;
          res.timer_cmd = TCMD_START;
        end
        next_seq = (s + 1) % SEQN;
      end else res = empty_result(ST_REFUSED);
      res.last = 1'b1;
      pending_results.push_back(res);
    end else if (r.kind == KIND_ACK) begin
      a = $signed(r.ack_f);
      sum = $signed(r.seq_f) + a + byte_sum(r.lo, r.mid, r.hi);
      if (sum == $signed(r.sum_f) && a >= 0 && a < SEQN && window_has(a)) begin
        res = empty_result(ST_ACKED);
        acked[a] = 1'b1;
        if (timing[a]) begin
          timing[a] = 1'b0;
          res.timer_cmd = TCMD_STOP;
        end
        for (int k = 0; k < SEQN && acked[win_base]; k++) begin
          acked[win_base] = 1'b0;
          win_base = (win_base + 1) % SEQN;
        end
      end else res = empty_result(ST_IGNORED);
      res.last = 1'b1;
      pending_results.push_back(res);
    end else if (r.kind == KIND_TIMER) begin
      for (int i = 0; i < SEQN && n < MaxResults; i++) begin
        if (timing[i] && !acked[i] && window_has(i)) begin
          res = empty_result(ST_SENT);
          res.has_packet = 1'b1; res.out_seq = i[3:0]; res.out_sum = st_sum[i];
          res.w_low = st_lo[i]; res.w_mid = st_mid[i]; res.w_high = st_hi[i];
          res.timer_cmd = TCMD_START;
          pending_results.push_back(res);
          n++;
        end
      end
      if (n == 0) pending_results.push_back(empty_result(ST_SENT));
      pending_results[$].last = 1'b1;
    end else begin
      res = empty_result(ST_IGNORED);
      res.last = 1'b1;
      pending_results.push_back(res);
    end
  endtask

  // result checker and receiver stalls
  initial begin
    int gap;
    pkt_result_t got;
    pkt_result_t want;
    logic [1:0] pin;
    logic [2:0] pin_entry;
    out_ch.ready = 1'b0;
    errors = 0;
    mismatches = 0;
    gap = 0;
    @(negedge clk);
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.has_packet, out_ch.out_seq, out_ch.out_sum, out_ch.out_word_low,
                out_ch.out_word_mid, out_ch.out_word_high, out_ch.timer_cmd,
                out_ch.status, out_ch.last};
        if (pending_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", got);
        end else begin
          want = pending_results.pop_front();
          pin = want.status;
          if (got.last && pinned_status.size() > 0) begin
            pin_entry = pinned_status.pop_front();
            if (pin_entry[2]) pin = pin_entry[1:0];
          end
          if (got !== want || got.status !== pin) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
        gap = rx_stall_on ? $urandom_range(0, 13) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        gap--;
      end else out_ch.ready <= 1'b1;
    end
  end

  // drive one request and wait for its acceptance
  task automatic send_request(input stim_row_t r, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind <= r.kind;
    in_ch.pkt_seq_in <= r.seq_f;
    in_ch.pkt_ack_in <= r.ack_f;
    in_ch.pkt_sum_in <= r.sum_f;
    in_ch.data_word_low <= r.lo;
    in_ch.data_word_mid <= r.mid;
    in_ch.data_word_high <= r.hi;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(r);
    pinned_status.push_back({r.has_exp, r.exp_status});
  endtask

  // drop the request valid after the last acceptance
  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic stim_row_t make_row(logic [1:0] k, logic [63:0] lo, logic [63:0] mid,
                                        logic [31:0] hi);
    stim_row_t r;
    r.kind = k; r.lo = lo; r.mid = mid; r.hi = hi;
    r.seq_f = 16'($urandom); r.ack_f = 16'($urandom); r.sum_f = 16'($urandom);
    r.has_exp = 1'b0; r.exp_status = ST_SENT;
    return r;
  endfunction

  // build an ack whose checksum is right, for the given acknum
  function automatic stim_row_t good_ack(int a);
    stim_row_t r;
    int sum;
    r = make_row(KIND_ACK, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
    // seq kept small enough that the sum fits the 16-bit checksum field
    r.seq_f = 16'(int'($urandom_range(0, 32767)) - 16384);
    r.ack_f = 16'(a);
    sum = $signed(r.seq_f) + a + byte_sum(r.lo, r.mid, r.hi);
    r.sum_f = 16'(sum);
    return r;
  endfunction

  function automatic stim_row_t pinned(stim_row_t r, logic [1:0] st);
    r.has_exp = 1'b1; r.exp_status = st;
    return r;
  endfunction

  task automatic wait_drained();
    release_input();
    while (pending_results.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    stim_row_t plan[$];
    stim_row_t r;
    int pick;
    int gap;
    win_base = 0; next_seq = 0;
    rx_stall_on = 1;
    for (int i = 0; i < SEQN; i++) begin
      acked[i] = 0; timing[i] = 0;
      st_lo[i] = '0; st_mid[i] = '0; st_hi[i] = '0; st_sum[i] = '0;
    end
    in_ch.valid = 1'b0; in_ch.kind = KIND_SEND;
    in_ch.pkt_seq_in = '0; in_ch.pkt_ack_in = '0; in_ch.pkt_sum_in = '0;
    in_ch.data_word_low = '0; in_ch.data_word_mid = '0; in_ch.data_word_high = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: empty timer, extremes, refusal, bad acks, unknown kind
    plan.push_back(pinned(make_row(KIND_TIMER, '0, '0, '0), ST_SENT));
    plan.push_back(pinned(make_row(2'd3, '1, '1, '1), ST_IGNORED));
    plan.push_back(make_row(KIND_SEND, '0, '0, '0));
    plan.push_back(make_row(KIND_SEND, '1, '1, '1));
    for (int i = 0; i < 4; i++)
      plan.push_back(make_row(KIND_SEND, {$urandom, $urandom}, {$urandom, $urandom}, $urandom));
    plan.push_back(pinned(make_row(KIND_SEND, '1, '0, '1), ST_REFUSED));
    plan.push_back(make_row(KIND_TIMER, '0, '0, '0));
    r = good_ack(-1); plan.push_back(pinned(r, ST_IGNORED));
    r = good_ack(12); plan.push_back(pinned(r, ST_IGNORED));
    r = good_ack(32767); plan.push_back(pinned(r, ST_IGNORED));
    r = good_ack(-32768); plan.push_back(pinned(r, ST_IGNORED));
    r = good_ack(7); plan.push_back(pinned(r, ST_IGNORED));
    r = good_ack(2); r.sum_f = r.sum_f + 16'd1; plan.push_back(pinned(r, ST_IGNORED));
    r = good_ack(1); plan.push_back(pinned(r, ST_ACKED));
    r = good_ack(1); plan.push_back(pinned(r, ST_ACKED));
    r = good_ack(0); plan.push_back(pinned(r, ST_ACKED));
    plan.push_back(make_row(KIND_TIMER, '0, '0, '0));
    r = good_ack(5); r.seq_f = 16'h8000; r.sum_f = 16'(-32768 + 5 + byte_sum(r.lo, r.mid, r.hi));
    plan.push_back(r);
    r = good_ack(3); r.seq_f = 16'h7fff; r.sum_f = 16'(32767 + 3 + byte_sum(r.lo, r.mid, r.hi));
    plan.push_back(r);
    foreach (plan[i]) send_request(plan[i], $urandom_range(0, 13));

    // pause with the pipe fully drained
    wait_drained();

    // random traffic: mostly sends and valid acks, some noise
    for (int n = 0; n < 250; n++) begin
      if (n == 120) wait_drained();
      rx_stall_on = !(n >= 60 && n < 90);
      pick = $urandom_range(0, 99);
      if (pick < 40)
        r = make_row(KIND_SEND, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      else if (pick < 75)
        r = good_ack((win_base + $urandom_range(0, WIN - 1)) % SEQN);
      else if (pick < 83)
        r = good_ack($urandom_range(0, SEQN - 1));
      else if (pick < 90)
        r = make_row(KIND_ACK, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      else if (pick < 97)
        r = make_row(KIND_TIMER, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      else
        r = make_row(2'd3, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      gap = (n >= 60 && n < 90) ? 0 : $urandom_range(0, 13);
      send_request(r, gap);
    end

    release_input();
    while (pending_results.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("** selective_repeat_sender: PASSED **");
    else
      $display("** selective_repeat_sender: FAILED **");
    $finish;
  end
endmodule
